/* rtl/pdrt_pkg.sv */
// Package for the packet delay release table.
// Holds field widths, status and command codes, and the result type of the
// shared time unit. No dependencies.
package pdrt_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int TIME_W      = 11;
	localparam int WORD_W      = 32;
	localparam int DRAW_W      = 7;
	localparam int ELAP_W      = 24;
	localparam int STATUS_W    = 2;
	localparam int IDX_OUT_W   = 4;

	localparam logic [DRAW_W-1:0] THR_RESET = 7'd10;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_RELEASED = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_TIME   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] remain_us;
		logic              expired;
	} sub_res_t;

endpackage

/* rtl/packet_delay_release_table_unit.sv */
// Insert: a dropped packet goes straight to its result; otherwise the slots
// are scanned from slot 0 for a free one. Time item: each slot is read through
// the table RAM read port and shared subtract unit, pausing on a stalled output.
// One item at a time; the input is not ready until its results are queued.
// Reset (arst_n, async): slot valid bits cleared, threshold set to 10,
// table contents undefined until written; no clearing pass.
module packet_delay_release_table_unit import pdrt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [DRAW_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  logic [WORD_W-1:0]    packet_word,
	input  logic [TIME_W-1:0]    delay_us,
	input  logic [DRAW_W-1:0]    drop_draw,
	input  logic [ELAP_W-1:0]    elapsed_us,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [IDX_OUT_W-1:0] slot_index,
	output logic [WORD_W-1:0]    released_word,
	output logic                 last
);

	localparam int IW   = $clog2(SLOTS);
	localparam int CW   = $clog2(MAX_RESULTS + 1);
	localparam int ENTW = TIME_W + WORD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_EMIT,
		S_RD,
		S_EX,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [DRAW_W-1:0]    thr_q;
	logic [SLOTS-1:0]     valid_q;
	logic [IW-1:0]        idx_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_W-1:0]    word_q;
	logic [TIME_W-1:0]    delay_q;
	logic [ELAP_W-1:0]    elapsed_q;
	status_t              res_status_q;
	logic [IDX_OUT_W-1:0] res_idx_q;
	logic                 pend_valid_q;
	logic [IDX_OUT_W-1:0] pend_idx_q;
	logic [WORD_W-1:0]    pend_word_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IDX_OUT_W-1:0] slot_index_q;
	logic [WORD_W-1:0]    released_word_q;
	logic                 last_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic                 idx_end;
	logic [IW+3:0]        idx_wide;
	logic [IDX_OUT_W-1:0] idx_out;
	logic [ENTW-1:0]      rdata;
	logic [ENTW-1:0]      wdata;
	logic                 we;
	sub_res_t             sub;
	logic                 rel;
	logic                 ex_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign idx_end   = (idx_q == IW'(SLOTS - 1));
	assign idx_wide  = {4'b0, idx_q};
	assign idx_out   = idx_wide[IDX_OUT_W-1:0];

	pdrt_sat_sub u_sub (
		.remain_us (rdata[ENTW-1:WORD_W]),
		.elapsed   (elapsed_q),
		.res       (sub)
	);

	assign rel   = valid_q[idx_q] && sub.expired && (cnt_q < CW'(MAX_RESULTS));
	assign ex_go = !(rel && pend_valid_q && !out_free);

	assign out_load = ((state_q == S_EMIT) && out_free)
		|| ((state_q == S_EX) && ex_go && rel && pend_valid_q)
		|| ((state_q == S_FLUSH) && pend_valid_q && out_free);

	always_comb begin
		we    = 1'b0;
		wdata = {delay_q, word_q};
		if (state_q == S_FIND) begin
			we = !valid_q[idx_q];
		end else if (state_q == S_EX) begin
			we    = ex_go && valid_q[idx_q] && !rel;
			wdata = {sub.remain_us, rdata[WORD_W-1:0]};
		end
	end

	pdrt_ram #(
		.WIDTH (ENTW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			thr_q        <= THR_RESET;
			valid_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						word_q    <= packet_word;
						delay_q   <= delay_us;
						elapsed_q <= elapsed_us;
						idx_q     <= '0;
						cnt_q     <= '0;
						if (command == CMD_TIME) begin
							state_q <= S_RD;
						end else if (drop_draw < thr_q) begin
							res_status_q <= ST_DROPPED;
							res_idx_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						res_status_q   <= ST_ACCEPTED;
						res_idx_q      <= idx_out;
						state_q        <= S_EMIT;
					end else if (idx_end) begin
						res_status_q <= ST_FULL;
						res_idx_q    <= '0;
						state_q      <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						status_q        <= res_status_q;
						slot_index_q    <= res_idx_q;
						released_word_q <= '0;
						last_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX: begin
					if (ex_go) begin
						if (rel) begin
							valid_q[idx_q] <= 1'b0;
							cnt_q          <= cnt_q + 1'b1;
							pend_valid_q   <= 1'b1;
							pend_idx_q     <= idx_out;
							pend_word_q    <= rdata[WORD_W-1:0];
							if (pend_valid_q) begin
								status_q        <= ST_RELEASED;
								slot_index_q    <= pend_idx_q;
								released_word_q <= pend_word_q;
								last_q          <= 1'b0;
							end
						end
						if (idx_end) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						status_q        <= ST_RELEASED;
						slot_index_q    <= pend_idx_q;
						released_word_q <= pend_word_q;
						last_q          <= 1'b1;
						pend_valid_q    <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_index_q;
	assign released_word = released_word_q;
	assign last          = last_q;

endmodule

/* rtl/pdrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the slot table; no dependencies.
module pdrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pdrt_sat_sub.sv */
// Shared time unit: saturating subtract of elapsed time from time left,
// with the expiry flag. Depends on pdrt_pkg.
module pdrt_sat_sub import pdrt_pkg::*; (
	input  logic [TIME_W-1:0] remain_us,
	input  logic [ELAP_W-1:0] elapsed,
	output sub_res_t          res
);

	logic [ELAP_W-1:0] ext;
	logic [ELAP_W-1:0] diff;
	logic              above;

	assign ext   = {{(ELAP_W-TIME_W){1'b0}}, remain_us};
	assign diff  = ext - elapsed;
	assign above = ext > elapsed;

	assign res.remain_us = above ? diff[TIME_W-1:0] : '0;
	assign res.expired   = !above;

endmodule

/* rtl/pdrt_checker.sv */
// Port-level checker for the packet delay release table, bound to the top.
// Depends on pdrt_pkg and packet_delay_release_table_unit.
module pdrt_checker import pdrt_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [STATUS_W-1:0]  status,
	input logic [IDX_OUT_W-1:0] slot_index,
	input logic [WORD_W-1:0]    released_word,
	input logic                 last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(slot_index) && $stable(released_word) && $stable(last))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_ins_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RELEASED |-> last && released_word == '0)
		else $error("insert result without last or with a word");

	a_ins_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DROPPED || status == ST_FULL) |-> slot_index == '0)
		else $error("dropped or full result with a slot index");

endmodule

bind packet_delay_release_table_unit pdrt_checker u_pdrt_checker (.*);
